// ===== design/trme_pkg.sv =====
// Shared types and constants for the toy register machine executor.
// Holds operation codes, controller states and the control/status structs.
// No dependencies.
`default_nettype none

package trme_pkg;

  // Operation codes of a decoded instruction; code 15 behaves as nop
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_MOV   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_JMP   = 4'd6,
    OP_JE    = 4'd7,
    OP_JNE   = 4'd8,
    OP_JG    = 4'd9,
    OP_JGE   = 4'd10,
    OP_JL    = 4'd11,
    OP_JLE   = 4'd12,
    OP_READ  = 4'd13,
    OP_PRINT = 4'd14
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  // Field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IMM_W  = 24;
  localparam int unsigned REG_W  = 2;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned TGT_W  = 7;
  localparam int unsigned RV_W   = 15;
  localparam int unsigned NREGS  = 4;

  // Stream word widths
  localparam int unsigned S_DATA_W = 80;
  localparam int unsigned S_USER_W = 6;
  localparam int unsigned M_DATA_W = 48;

  // Highest line index; sequential stepping saturates here
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming instruction word
    logic div_start;  // launch the iterative divider
    logic commit;     // write back state and load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;   // captured op is div with a nonzero divisor
    logic div_done;   // divider quotient is ready
    logic out_free;   // result register can take a word this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/trme_div.sv =====
// Iterative signed divider, one quotient bit per cycle (restoring).
// Truncates toward zero; the overflow case wraps. Uses trme_pkg.
`default_nettype none

module trme_div
  import trme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dsr;
  logic              neg;

  logic              n_neg;
  logic              d_neg;
  logic [WORD_W-1:0] n_mag;
  logic [WORD_W-1:0] d_mag;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              ge;

  // Operand magnitudes at launch
  assign n_neg = dividend[WORD_W-1];
  assign d_neg = divisor[WORD_W-1];
  assign n_mag = n_neg ? (~dividend + 1'b1) : dividend;
  assign d_mag = d_neg ? (~divisor + 1'b1) : divisor;

  // One restoring step
  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = !diff[WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (cnt == CNT_LAST)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // Remainder / quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= n_mag;
      dsr <= d_mag;
      neg <= n_neg ^ d_neg;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ge};
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

`default_nettype wire

// ===== design/trme_dpath.sv =====
// Datapath: instruction register, register file, line counter, ALU,
// branch compare, divider and result register. Uses trme_pkg, trme_div.
`default_nettype none

module trme_dpath
  import trme_pkg::*;
#(
  parameter int unsigned MAX_PROGRAM_LINES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  output dp_stat_t                 stat,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [S_USER_W-1:0] s_tuser,
  input  wire logic                cfg_wen,
  input  wire logic [LINE_W-1:0]   cfg_wdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata
);

  localparam int unsigned LW = $clog2(MAX_PROGRAM_LINES + 1);
  localparam int unsigned CW = (LW > LINE_W) ? LW : LINE_W;
  localparam logic [CW-1:0] MAX_LINES = CW'(MAX_PROGRAM_LINES);

  // Captured instruction
  op_t              op;
  logic             f_imm;
  logic [IMM_W-1:0] f_val;
  logic [REG_W-1:0] f_reg;
  logic             s_imm;
  logic [IMM_W-1:0] s_val;
  logic [REG_W-1:0] s_reg;
  logic [REG_W-1:0] d_reg;
  logic [TGT_W-1:0] tgt;
  logic [RV_W-1:0]  rdv;

  // Architectural state
  logic [WORD_W-1:0] regs [NREGS];
  logic [LINE_W-1:0] cur_line;
  logic [LINE_W-1:0] prog_len;

  // Result register fields
  logic [LINE_W-1:0] o_line;
  logic              o_halt;
  logic              o_pvalid;
  logic [WORD_W-1:0] o_pvalue;
  logic              o_pnl;
  logic              o_dz;

  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] second;
  logic [WORD_W-1:0] dst;
  logic              lt;
  logic              eq;
  logic              take;
  logic [LINE_W-1:0] next_seq;
  logic [LINE_W-1:0] next;
  logic              wb_en;
  logic [WORD_W-1:0] wb_val;
  logic [WORD_W-1:0] prod;
  logic              dz;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     limit;
  logic              halt;
  logic              div_done;
  logic [WORD_W-1:0] quot;

  // Latch the instruction word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= op_t'(s_tuser[3:0]);
      f_imm <= s_tuser[4];
      s_imm <= s_tuser[5];
      f_val <= s_tdata[23:0];
      f_reg <= s_tdata[25:24];
      s_val <= s_tdata[49:26];
      s_reg <= s_tdata[51:50];
      d_reg <= s_tdata[53:52];
      tgt   <= s_tdata[60:54];
      rdv   <= s_tdata[75:61];
    end
  end

  // Operand select
  assign src    = f_imm ? {{(WORD_W-IMM_W){1'b0}}, f_val} : regs[f_reg];
  assign second = s_imm ? {{(WORD_W-IMM_W){1'b0}}, s_val} : regs[s_reg];
  assign dst    = regs[d_reg];
  assign lt     = $signed(src) < $signed(second);
  assign eq     = src == second;
  assign prod   = src * dst;
  assign dz     = (op == OP_DIV) && (dst == '0);

  trme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (src),
    .divisor  (dst),
    .done     (div_done),
    .quotient (quot)
  );

  // Execute: branch decision and write-back value
  always_comb begin
    take   = 1'b0;
    wb_en  = 1'b0;
    wb_val = src;
    case (op)
      OP_MOV: begin
        wb_en = 1'b1;
      end
      OP_ADD: begin
        wb_en  = 1'b1;
        wb_val = dst + src;
      end
      OP_SUB: begin
        wb_en  = 1'b1;
        wb_val = dst - src;
      end
      OP_MUL: begin
        wb_en  = 1'b1;
        wb_val = prod;
      end
      OP_DIV: begin
        wb_en  = !dz;
        wb_val = quot;
      end
      OP_JMP: take = 1'b1;
      OP_JE:  take = eq;
      OP_JNE: take = !eq;
      OP_JG:  take = !lt && !eq;
      OP_JGE: take = !lt;
      OP_JL:  take = lt;
      OP_JLE: take = lt || eq;
      OP_READ: begin
        wb_en  = 1'b1;
        wb_val = {{(WORD_W-RV_W){rdv[RV_W-1]}}, rdv};
      end
      default: ;
    endcase
  end

  // Next line and halt check against the effective length
  assign next_seq = (cur_line == LINE_MAX) ? LINE_MAX : cur_line + 1'b1;
  assign next     = take ? {{(LINE_W-TGT_W){1'b0}}, tgt} : next_seq;
  assign len_ext  = CW'(prog_len);
  assign limit    = (len_ext < MAX_LINES) ? len_ext : MAX_LINES;
  assign halt     = CW'(next) >= limit;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
    end else if (cfg_wen) begin
      prog_len <= cfg_wdata;
    end
  end

  // Register file and line counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++) begin
        regs[i] <= '0;
      end
      cur_line <= '0;
    end else if (cmd.commit) begin
      if (wb_en) begin
        regs[d_reg] <= wb_val;
      end
      cur_line <= next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_line   <= next;
      o_halt   <= halt;
      o_pvalid <= op == OP_PRINT;
      o_pvalue <= (op == OP_PRINT) ? src : '0;
      o_pnl    <= (op == OP_PRINT) && !f_imm;
      o_dz     <= dz;
    end
  end

  assign m_tdata = {4'b0, o_dz, o_pnl, o_pvalue, o_pvalid, o_halt, o_line};

  // Status to the controller
  assign stat.need_div = (op == OP_DIV) && !dz;
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ===== design/trme_ctrl.sv =====
// Controller state machine: accept, execute, wait on divider, commit.
// Drives datapath commands from its status. Uses trme_pkg.
`default_nettype none

module trme_ctrl
  import trme_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (stat.div_done && stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/toy_register_machine_executor.sv =====
// Toy register machine executor, one decoded instruction per input word.
//
// Input stream (s_axis_*): one decoded instruction per word; the opcode and
// operand-kind flags ride in tuser, operands in tdata.
// Output stream (m_axis_*): one result word per instruction: next line,
// halt flag, print data and divide-by-zero flag.
// cfg_wen/cfg_wdata write program_length; write only while idle.
// Sequence: accept, the execute state, then the result is registered;
// a div with nonzero divisor also waits in the divide state on the
// bit-serial divider (one quotient bit per clock).
// One instruction is in flight at a time; s_axis_tready is high only when
// the controller is idle, so a new word is accepted only after the last
// one commits. A finished result waits in the output register while the
// next word is accepted; a stalled receiver holds further commits back.
// Reset (rst, synchronous) clears the registers, the line counter, the
// program length and the output valid.
// Uses trme_pkg, trme_ctrl, trme_dpath, trme_div.
`default_nettype none

module toy_register_machine_executor
  import trme_pkg::*;
#(
  parameter int unsigned MAX_PROGRAM_LINES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Input instruction stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [23:0] first_immediate, [25:24] first_register, [49:26] second_immediate,
  // [51:50] second_register, [53:52] dest_register, [60:54] jump_target,
  // [75:61] read_value, [79:76] zero
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // [3:0] operation, [4] first_is_immediate, [5] second_is_immediate
  input  wire logic [S_USER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] next_line, [8] halted, [9] print_valid, [41:10] print_value,
  // [42] print_newline, [43] divide_by_zero, [47:44] zero
  output logic [M_DATA_W-1:0]      m_axis_tdata,
  // program_length register
  input  wire logic                cfg_wen,
  input  wire logic [LINE_W-1:0]   cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  trme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trme_dpath #(
    .MAX_PROGRAM_LINES (MAX_PROGRAM_LINES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/trme_check.sv =====
// Port-level checker for the executor, attached by bind.
// Watches the two streams; depends on trme_pkg.
`default_nettype none

module trme_check
  import trme_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [M_DATA_W-1:0] m_axis_tdata
);

  // No result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // One instruction at a time: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an instruction is executing");

  // A stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Newline flag only on a print
  a_nl_print: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[42] || m_axis_tdata[9]))
    else $error("print_newline without print_valid");

  // Print value is zero when nothing prints
  a_pv_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[9]) |-> (m_axis_tdata[41:10] == '0))
    else $error("print_value nonzero without print_valid");

endmodule

bind toy_register_machine_executor trme_check u_trme_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_toy_register_machine_executor.sv =====
// Self-checking testbench for the toy register machine executor.
// Streams decoded instructions in, predicts each result word, and checks the results.
// Depends on trme_pkg and toy_register_machine_executor.
`timescale 1ns / 1ps

module tb_toy_register_machine_executor;
  import trme_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam logic [REG_W-1:0] RA = 2'd0, RB = 2'd1, RC = 2'd2, RD = 2'd3;

  // One decoded instruction
  typedef struct packed {
    logic [3:0]       op;
    logic             fi;
    logic [IMM_W-1:0] fimm;
    logic [REG_W-1:0] freg;
    logic             si;
    logic [IMM_W-1:0] simm;
    logic [REG_W-1:0] sreg;
    logic [REG_W-1:0] dreg;
    logic [TGT_W-1:0] tgt;
    logic [RV_W-1:0]  rv;
  } instr_t;

  // One result word, unpacked
  typedef struct packed {
    logic [LINE_W-1:0] next_line;
    logic              halted;
    logic              pvalid;
    logic [WORD_W-1:0] pvalue;
    logic              pnl;
    logic              dz;
  } outcome_t;

  // Machine state mirror plus queue of outcomes still owed by the block
  class machine_tracker;
    logic [WORD_W-1:0] gpr[NREGS];
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] prog_len;
    outcome_t          owed[$];
    int errors, n_in, n_out, n_dz, n_taken, n_prints, n_sat;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      line = '0;
      prog_len = '0;
    endfunction

    function void set_length(logic [LINE_W-1:0] len);
      prog_len = len;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Signed divide by magnitudes; min / -1 wraps back to min
    function logic [WORD_W-1:0] signed_quot(logic [WORD_W-1:0] n, logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] un, ud, q;
      un = n[WORD_W-1] ? -n : n;
      ud = d[WORD_W-1] ? -d : d;
      q = un / ud;
      return (n[WORD_W-1] != d[WORD_W-1]) ? -q : q;
    endfunction

    // Execute one accepted instruction against the mirror
    function void note_instr(instr_t it);
      logic [WORD_W-1:0] src, sec, dst;
      logic [LINE_W-1:0] nxt;
      bit take;
      int lim;
      outcome_t r;
      src = it.fi ? {8'd0, it.fimm} : gpr[it.freg];
      sec = it.si ? {8'd0, it.simm} : gpr[it.sreg];
      dst = gpr[it.dreg];
      nxt = (line == LINE_MAX) ? LINE_MAX : line + 1'b1;
      take = 0;
      r = '0;
      case (it.op)
        OP_MOV:   gpr[it.dreg] = src;
        OP_ADD:   gpr[it.dreg] = dst + src;
        OP_SUB:   gpr[it.dreg] = dst - src;
        OP_MUL:   gpr[it.dreg] = dst * src;
        OP_DIV: begin
          if (dst == '0) r.dz = 1'b1;
          else gpr[it.dreg] = signed_quot(src, dst);
        end
        OP_JMP:   take = 1;
        OP_JE:    take = ($signed(src) == $signed(sec));
        OP_JNE:   take = ($signed(src) != $signed(sec));
        OP_JG:    take = ($signed(src) > $signed(sec));
        OP_JGE:   take = ($signed(src) >= $signed(sec));
        OP_JL:    take = ($signed(src) < $signed(sec));
        OP_JLE:   take = ($signed(src) <= $signed(sec));
        OP_READ:  gpr[it.dreg] = {{(WORD_W-RV_W){it.rv[RV_W-1]}}, it.rv};
        OP_PRINT: begin
          r.pvalid = 1'b1;
          r.pvalue = src;
          r.pnl = !it.fi;
        end
        default: ;
      endcase
      if (take) nxt = {1'b0, it.tgt};
      line = nxt;
      lim = (prog_len < 128) ? int'(prog_len) : 128;
      r.next_line = nxt;
      r.halted = (int'(nxt) >= lim);
      owed.push_back(r);
      n_in++;
      n_dz += r.dz;
      n_taken += take;
      n_prints += r.pvalid;
      if (nxt == LINE_MAX) n_sat++;
    endfunction

    task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("MISMATCH word %0d: %s got %0h expected %0h", n_out, what, got, want);
      errors++;
    endtask

    // Compare one accepted result word with the oldest owed outcome
    task check_outcome(logic [M_DATA_W-1:0] w);
      outcome_t e;
      if (owed.size() == 0) begin
        report("unexpected result word", w[WORD_W-1:0], '0);
      end else begin
        e = owed.pop_front();
        if (w[7:0] !== e.next_line) report("next_line", w[7:0], e.next_line);
        if (w[8] !== e.halted) report("halted", w[8], e.halted);
        if (w[9] !== e.pvalid) report("print_valid", w[9], e.pvalid);
        if (w[41:10] !== e.pvalue) report("print_value", w[41:10], e.pvalue);
        if (w[42] !== e.pnl) report("print_newline", w[42], e.pnl);
        if (w[43] !== e.dz) report("divide_by_zero", w[43], e.dz);
      end
      n_out++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic cfg_wen = 1'b0;
  logic [LINE_W-1:0] cfg_wdata = '0;

  machine_tracker tracker = new();
  bit calm = 0;        // no idling on either side while set
  bit held_once = 0;
  int hold_left = 0;
  int cycles = 0;

  toy_register_machine_executor uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check accepted words, random stalls, one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) tracker.check_outcome(m_axis_tdata);
      if (!held_once && tracker.n_in >= 400) begin
        held_once = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  function automatic instr_t mk(logic [3:0] op, logic [REG_W-1:0] dr, logic fi,
                                logic [IMM_W-1:0] fv, logic si = 1'b1,
                                logic [IMM_W-1:0] sv = '0, logic [TGT_W-1:0] tg = '0,
                                logic [RV_W-1:0] rv = '0);
    instr_t it;
    it.op = op;
    it.dreg = dr;
    it.fi = fi;
    it.fimm = fv;
    it.freg = fv[REG_W-1:0];
    it.si = si;
    it.simm = sv;
    it.sreg = sv[REG_W-1:0];
    it.tgt = tg;
    it.rv = rv;
    return it;
  endfunction

  function automatic logic [IMM_W-1:0] rand_imm();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return IMM_W'($urandom_range(0, 15));
      5: return 24'h800000;
      default: return IMM_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [RV_W-1:0] rand_read_value();
    case ($urandom_range(0, 9))
      0: return 15'h4000;
      1: return 15'h3FFF;
      2: return 15'h7FFF;
      3, 4, 5: return RV_W'($urandom_range(0, 16) - 8);
      default: return RV_W'($urandom_range(0, 15'h7FFF));
    endcase
  endfunction

  function automatic instr_t rand_instr(bit jumps);
    instr_t it;
    it.op = 4'($urandom_range(0, 15));
    // without jumps, fold branch codes onto nop and the arithmetic ones
    if (!jumps && it.op >= OP_JMP && it.op <= OP_JLE) it.op = it.op - 4'd7;
    it.fi = 1'($urandom_range(0, 1));
    it.fimm = rand_imm();
    it.freg = REG_W'($urandom_range(0, 3));
    it.si = 1'($urandom_range(0, 1));
    it.simm = rand_imm();
    it.sreg = REG_W'($urandom_range(0, 3));
    it.dreg = REG_W'($urandom_range(0, 3));
    it.tgt = TGT_W'($urandom_range(0, 127));
    it.rv = rand_read_value();
    return it;
  endfunction

  // Offer one instruction word and hold it until accepted
  task automatic send(instr_t it);
    while (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, it.rv, it.tgt, it.dreg, it.sreg, it.simm, it.freg, it.fimm};
    s_axis_tuser <= {it.si, it.fi, it.op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_instr(it);
  endtask

  // Drain, then write program_length while the block is idle
  task automatic set_length(logic [LINE_W-1:0] len);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tracker.set_length(len);
  endtask

  task automatic random_phase(logic [LINE_W-1:0] len, int count, bit jumps);
    set_length(len);
    repeat (count) send(rand_instr(jumps));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, wraps, divide corner cases, every branch kind
    set_length(8'd10);
    send(mk(OP_NOP, RA, 1, '0));
    send(mk(OP_MOV, RA, 1, 24'hFFFFFF));
    send(mk(OP_MOV, RB, 1, 24'h800000));
    send(mk(OP_MUL, RB, 1, 24'd256));                    // b = most negative
    send(mk(OP_READ, RC, 1, '0, 1, '0, '0, 15'h7FFF));   // c = -1
    send(mk(OP_DIV, RC, 0, RB));                         // min / -1 wraps
    send(mk(OP_DIV, RD, 1, 24'd5));                      // zero divisor
    send(mk(OP_READ, RD, 1, '0, 1, '0, '0, 15'h4000));
    send(mk(OP_READ, RD, 1, '0, 1, '0, '0, 15'h3FFF));
    send(mk(OP_DIV, RD, 0, RC));                         // negative quotient
    send(mk(OP_SUB, RA, 0, RD));
    send(mk(OP_ADD, RB, 0, RB));                         // wraps to zero
    send(mk(OP_MUL, RA, 0, RA));
    send(mk(OP_JE, RA, 0, RC, 0, RC, 7'd3));
    send(mk(OP_JNE, RA, 1, 24'd1, 1, 24'd1, 7'd50));
    send(mk(OP_JG, RA, 0, RC, 1, '0, 7'd60));            // negative vs zero
    send(mk(OP_JGE, RA, 1, '0, 0, RC, 7'd127));          // jump past the end
    send(mk(OP_JL, RA, 0, RC, 1, 24'hFFFFFF, 7'd0));
    send(mk(OP_JLE, RA, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 7'd9));
    send(mk(OP_JMP, RA, 1, '0, 1, '0, 7'd126));
    send(mk(OP_PRINT, RA, 1, 24'hFFFFFF));
    send(mk(OP_PRINT, RA, 0, RC));
    send(mk(OP_UNUSED, RA, 1, 24'h123456));
    send(mk(OP_DIV, RB, 0, RA));                         // b is zero again

    // Straight-line run with no idling; walks the line counter into saturation
    calm = 1;
    random_phase(8'd128, 200, 0);
    calm = 0;

    random_phase(8'd0, 100, 1);
    random_phase(8'd255, 100, 1);
    random_phase(8'd1, 100, 1);
    random_phase(8'd37, 100, 1);
    random_phase(LINE_W'($urandom_range(2, 127)), 100, 1);
    random_phase(8'd128, 100, 1);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d instructions, %0d result words: %0d branches taken, %0d prints,",
             tracker.n_in, tracker.n_out, tracker.n_taken, tracker.n_prints);
    $display("%0d zero divisors, %0d steps at the saturated line, %0d mismatches.",
             tracker.n_dz, tracker.n_sat, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
